@@ design/imu_pitch_complementary_filter_core_macros.svh @@
// Assertion macros for the pitch filter core
`ifndef IMU_PITCH_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define IMU_PITCH_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IPF_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IPF_ASSERT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define IPF_ASSERT_IMPL(label, clk, rst_n, prop)
`define IPF_ASSERT_RESET(label, clk, prop)
`endif
`endif

@@ design/ipcf_pkg.sv @@
// Shared types, constants and the arctangent table of the pitch filter
`timescale 1ns / 1ps
package ipcf_pkg;
    localparam int CordicSteps  = 16;
    localparam int TableLen     = 24;
    localparam int NumSteps     = (CordicSteps > TableLen) ? TableLen : CordicSteps;
    localparam int StepW        = $clog2(NumSteps + 1);
    localparam int CordW        = 48;   // vector magnitude grows past 2^29
    localparam int ZW           = 26;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 20;
    localparam logic [CfgIdxW-1:0] RegGyroOff  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegAyOff    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegAzOff    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegIntGain  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegBlend    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegWindow   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegBias     = 3'd6;
    localparam logic signed [23:0] Sat24Max = 24'sh7FFFFF;
    localparam logic signed [23:0] Sat24Min = -24'sh800000;
    localparam logic signed [15:0] PitchLim = 16'sd23040;
    localparam logic signed [ZW-1:0] Z180   = 26'sd11796480;

    typedef struct packed {
        logic load;     // capture sample, do offsets and gyro product
        logic integ;    // integrate, start CORDIC
        logic iter;     // one CORDIC step
        logic fuse;     // pitch, window, blend product
        logic finish;   // store angle, present result
    } t_cmd;

    typedef struct packed {
        logic cordic_last;
    } t_status;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 26'sd2949120;  5'd1: atan_q16 = 26'sd1740967;
            5'd2: atan_q16 = 26'sd919879;   5'd3: atan_q16 = 26'sd466945;
            5'd4: atan_q16 = 26'sd234379;   5'd5: atan_q16 = 26'sd117304;
            5'd6: atan_q16 = 26'sd58666;    5'd7: atan_q16 = 26'sd29335;
            5'd8: atan_q16 = 26'sd14668;    5'd9: atan_q16 = 26'sd7334;
            5'd10: atan_q16 = 26'sd3667;    5'd11: atan_q16 = 26'sd1833;
            5'd12: atan_q16 = 26'sd917;     5'd13: atan_q16 = 26'sd458;
            5'd14: atan_q16 = 26'sd229;     5'd15: atan_q16 = 26'sd115;
            5'd16: atan_q16 = 26'sd57;      5'd17: atan_q16 = 26'sd29;
            5'd18: atan_q16 = 26'sd14;      5'd19: atan_q16 = 26'sd7;
            5'd20: atan_q16 = 26'sd4;       5'd21: atan_q16 = 26'sd2;
            5'd22: atan_q16 = 26'sd1;
            default: atan_q16 = 26'sd0;
        endcase
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'(Sat24Max)) sat24 = Sat24Max;
        else if (v < 28'(Sat24Min)) sat24 = Sat24Min;
        else sat24 = v[23:0];
    endfunction
endpackage

@@ design/imu_pitch_complementary_filter_core.sv @@
// Top level: IMU pitch complementary filter with stream ports
// A sample passes the load, integrate, CORDIC step, fuse and finish states in order.
// No new sample is taken while one is in those states, as the work is done by
// the single shared CORDIC stage.
// A new sample is taken only once the prior result has left or leaves that cycle.
// Reset (i_rst_n low, synchronous) clears the angle and loads register defaults.
`timescale 1ns / 1ps
module imu_pitch_complementary_filter_core import ipcf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [47:0]         s_axis_tdata,  // gyro_x, accel_y, accel_z
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,  // fused_pitch, accel_pitch
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;
    logic signed [23:0] w_fused;
    logic signed [15:0] w_accel;

    ipcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ipcf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_gyro_x      (s_axis_tdata[15:0]),
        .i_accel_y     (s_axis_tdata[31:16]),
        .i_accel_z     (s_axis_tdata[47:32]),
        .o_fused_pitch (w_fused),
        .o_accel_pitch (w_accel)
    );

    assign m_axis_tdata = {w_accel, w_fused};
endmodule

@@ design/ipcf_ctrl.sv @@
// Sequencer for the pitch filter: load, integrate, CORDIC steps, fuse, result
`timescale 1ns / 1ps
`include "imu_pitch_complementary_filter_core_macros.svh"
module ipcf_ctrl import ipcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INTEG = 5'b00010,
        S_ITER  = 5'b00100,
        S_FUSE  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // accept a new sample once no result waits, or the waiting one leaves this cycle
    assign o_in_ready  = (r_state == S_IDLE) && !(r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_INTEG;
                end
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_status.cordic_last) n_state = S_FUSE;
            end
            S_FUSE: begin
                o_cmd.fuse = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `IPF_ASSERT_IMPL(a_fin_sets_valid, i_clk, i_rst_n, (r_state == S_FIN) |=> r_out_valid)
    `IPF_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_in_ready)
    `IPF_ASSERT_IMPL(a_iter_ends, i_clk, i_rst_n, (r_state == S_ITER && i_status.cordic_last) |=> (r_state == S_FUSE))
endmodule

@@ design/ipcf_datapath.sv @@
// Datapath: offsets, gyro integration, shared CORDIC stage, window and blend
`timescale 1ns / 1ps
module ipcf_datapath import ipcf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic signed [15:0]  i_gyro_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    output logic signed [23:0]  o_fused_pitch,
    output logic signed [15:0]  o_accel_pitch
);
    logic signed [19:0] r_gyro_off, r_ay_off, r_az_off;
    logic        [15:0] r_int_gain, r_blend, r_window;
    logic signed [16:0] r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_off <= 20'sd24;
            r_ay_off   <= 20'sd21;
            r_az_off   <= 20'sd160;
            r_int_gain <= 16'd639;
            r_blend    <= 16'd328;
            r_window   <= 16'd2560;
            r_bias     <= 17'sd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegGyroOff: r_gyro_off <= i_cfg_data;
                RegAyOff:   r_ay_off   <= i_cfg_data;
                RegAzOff:   r_az_off   <= i_cfg_data;
                RegIntGain: r_int_gain <= i_cfg_data[15:0];
                RegBlend:   r_blend    <= i_cfg_data[15:0];
                RegWindow:  r_window   <= i_cfg_data[15:0];
                RegBias:    r_bias     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic signed [23:0]      r_angle;
    logic signed [38:0]      r_prod;
    logic signed [23:0]      r_g;
    logic signed [CordW-1:0] r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic [StepW-1:0]        r_step;
    logic signed [15:0]      r_pitch;

    logic signed [21:0] w_ay, w_az, w_rate;
    assign w_rate = {{2{i_gyro_x[15]}}, i_gyro_x, 4'b0} - 22'(r_gyro_off);
    assign w_ay   = {{2{i_accel_y[15]}}, i_accel_y, 4'b0} - 22'(r_ay_off);
    assign w_az   = {{2{i_accel_z[15]}}, i_accel_z, 4'b0} - 22'(r_az_off);

    logic signed [CordW-1:0] w_dx, w_dy;
    logic [4:0]              w_tidx;
    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_tidx = 5'(r_step);
    assign o_status.cordic_last = (r_step == StepW'(NumSteps - 1)) || (NumSteps == 0);

    // pitch from the finished angle, window limits
    logic signed [ZW-1:0] w_pz;
    logic signed [17:0]   w_pitch_raw;
    logic signed [15:0]   w_pitch;
    logic signed [25:0]   w_hi, w_lo, w_lim, w_err;
    assign w_pz        = -r_z + ZW'(128);
    assign w_pitch_raw = w_pz[25:8];
    assign w_pitch     = (w_pitch_raw > 18'(PitchLim)) ? PitchLim :
                         (w_pitch_raw < -18'(PitchLim)) ? -PitchLim : w_pitch_raw[15:0];
    assign w_hi  = 26'(r_g) + 26'($signed({1'b0, r_window}));
    assign w_lo  = 26'(r_g) - 26'($signed({1'b0, r_window}));
    assign w_lim = (26'(w_pitch) >= w_hi) ? w_hi :
                   (26'(w_pitch) <= w_lo) ? w_lo : 26'(w_pitch);
    assign w_err = w_lim - 26'(r_g);

    // products at full width: signed operands sign-extended, gains zero-extended, before the multiply
    logic signed [38:0] w_iprod, w_bprod;
    assign w_iprod = 39'(w_rate) * 39'($signed({1'b0, r_int_gain}));
    assign w_bprod = 39'(w_err) * 39'($signed({1'b0, r_blend}));

    logic signed [42:0] w_bsum;
    logic signed [27:0] w_new;
    logic signed [23:0] w_new_sat;
    assign w_bsum    = 43'(r_prod) + 43'sd32768;
    assign w_new     = 28'(r_g) + 28'(w_bsum >>> 16);
    assign w_new_sat = sat24(w_new);

    logic signed [39:0] w_isum;
    assign w_isum = 40'(r_prod) + 40'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_cmd.finish) begin
            r_angle <= w_new_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= w_iprod;
            r_step <= '0;
            if (w_az < 0) begin
                r_x <= -(CordW'(w_az) <<< 8);
                r_y <= -(CordW'(w_ay) <<< 8);
                r_z <= (w_ay >= 0) ? Z180 : -Z180;
            end else begin
                r_x <= CordW'(w_az) <<< 8;
                r_y <= CordW'(w_ay) <<< 8;
                r_z <= '0;
            end
        end
        if (i_cmd.integ) begin
            r_g <= sat24(28'(r_angle) + 28'(w_isum >>> 16));
        end
        if (i_cmd.iter) begin
            // zero vector keeps angle at zero: y stays >= 0 but x stays 0 too
            if (r_x == 0 && r_y == 0) begin
                r_z <= r_z;
            end else if (r_y >= 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + atan_q16(w_tidx);
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - atan_q16(w_tidx);
            end
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.fuse) begin
            r_pitch <= w_pitch;
            r_prod  <= w_bprod;
        end
        if (i_cmd.finish) begin
            o_fused_pitch <= sat24(28'(w_new_sat) - 28'(r_bias));
            o_accel_pitch <= r_pitch;
        end
    end
endmodule
